>>> rtl/nta_pkg.sv
// Shared types, constants and helper functions for the number-to-ASCII formatter.
// No dependencies; used by nta_datapath, nta_ctrl and the top level.
`default_nettype none

package nta_pkg;

    localparam int DEC_DIGITS = 8;
    localparam int HEX_DIGITS = 8;
    localparam int REM_W      = 27;    // holds any decimal remainder below the limit
    localparam int POS_W      = 4;     // digit position, 1 to 8

    localparam logic [31:0] DEC_LIMIT   = 32'd100000000;
    localparam logic [3:0]  NIBBLE_MASK = 4'hF;

    localparam logic [1:0] MODE_DEC = 2'd0;

    // Multiples 0..9 of each power-of-ten weight, built at elaboration.
    typedef logic [DEC_DIGITS-1:0][9:0][REM_W-1:0] dec_mult_t;

    function automatic dec_mult_t dec_mult_build();
        dec_mult_t   tbl;
        int unsigned wt;
        tbl = '0;
        wt  = 1;
        for (int p = 0; p < DEC_DIGITS; p++) begin
            for (int m = 0; m < 10; m++) begin
                tbl[p][m] = REM_W'(wt * m);
            end
            wt = wt * 10;
        end
        return tbl;
    endfunction

    localparam dec_mult_t DEC_MULT = dec_mult_build();

    function automatic logic [7:0] nibble_to_ascii(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        base = upper ? 8'h41 : 8'h61;
        if (nib < 4'd10) begin
            return 8'h30 + {4'h0, nib};
        end
        return base + {4'h0, nib} - 8'd10;
    endfunction

    typedef struct packed {
        logic load;   // capture a new input item
        logic step;   // produce one character
    } nta_cmd_t;

    typedef struct packed {
        logic emit;   // current step yields a visible character
        logic last;   // current step is the final one of the item
    } nta_sts_t;

endpackage

`default_nettype wire

>>> rtl/nta_datapath.sv
// Datapath: digit extraction by compare-and-subtract, hex nibble shifter, output payload.
// Depends on nta_pkg; commanded by nta_ctrl.
`default_nettype none

module nta_datapath
    import nta_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic [1:0]  s_mode,
    input  wire logic [31:0] s_value,
    input  wire logic [3:0]  s_hex_width,
    input  wire nta_cmd_t    cmd,
    output nta_sts_t         sts,
    output logic [7:0]       m_digit_char,
    output logic             m_last_char,
    output logic             m_too_large
);

    logic [31:0]      data_reg, data_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             dec_reg, dec_next;
    logic             upper_reg, upper_next;
    logic             err_reg, err_next;
    logic             seen_reg, seen_next;
    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;
    logic             big_reg, big_next;

    logic [3:0]       hex_w;
    logic [2:0]       hex_pad;
    logic [2:0]       widx;
    logic [3:0]       digit;
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] sub;
    logic [7:0]       step_char;
    logic             emit;
    logic             last;

    always_comb begin
        hex_w = ((s_hex_width == 4'd0) || (s_hex_width > 4'(HEX_DIGITS)))
              ? 4'(HEX_DIGITS) : s_hex_width;
        hex_pad = 3'(4'(HEX_DIGITS) - hex_w);
    end

    // One decimal digit: the largest multiple of the current weight that fits.
    always_comb begin
        widx  = 3'(pos_reg - 4'd1);
        rem   = data_reg[REM_W-1:0];
        digit = 4'd0;
        for (int m = 1; m < 10; m++) begin
            if (rem >= DEC_MULT[widx][m]) begin
                digit = 4'(m);
            end
        end
        sub = DEC_MULT[widx][digit];
    end

    always_comb begin
        last = (pos_reg == 4'd1);
        if (err_reg) begin
            step_char = 8'h00;
            emit      = 1'b1;
        end else if (dec_reg) begin
            step_char = 8'h30 + {4'h0, digit};
            // Leading zeros are dropped, but a lone zero still prints.
            emit      = (digit != 4'd0) || seen_reg || last;
        end else begin
            step_char = nibble_to_ascii(data_reg[31:28] & NIBBLE_MASK, upper_reg);
            emit      = 1'b1;
        end
        sts.emit = emit;
        sts.last = last;
    end

    always_comb begin
        data_next  = data_reg;
        pos_next   = pos_reg;
        dec_next   = dec_reg;
        upper_next = upper_reg;
        err_next   = err_reg;
        seen_next  = seen_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        big_next   = big_reg;
        if (cmd.load) begin
            dec_next   = (s_mode == MODE_DEC);
            upper_next = s_mode[1];
            seen_next  = 1'b0;
            if (s_mode == MODE_DEC) begin
                data_next = s_value;
                err_next  = (s_value >= DEC_LIMIT);
                pos_next  = (s_value >= DEC_LIMIT) ? 4'd1 : 4'(DEC_DIGITS);
            end else begin
                // Left-align so the most significant emitted nibble sits on top.
                data_next = s_value << {hex_pad, 2'b00};
                err_next  = 1'b0;
                pos_next  = hex_w;
            end
        end else if (cmd.step) begin
            pos_next = pos_reg - 4'd1;
            if (dec_reg) begin
                data_next = {{(32-REM_W){1'b0}}, rem - sub};
                seen_next = seen_reg || (digit != 4'd0);
            end else begin
                data_next = {data_reg[27:0], 4'h0};
            end
            if (emit) begin
                char_next = step_char;
                last_next = last;
                big_next  = err_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg  <= data_next;
        pos_reg   <= pos_next;
        dec_reg   <= dec_next;
        upper_reg <= upper_next;
        err_reg   <= err_next;
        seen_reg  <= seen_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        big_reg   <= big_next;
    end

    assign m_digit_char = char_reg;
    assign m_last_char  = last_reg;
    assign m_too_large  = big_reg;

endmodule

`default_nettype wire

>>> rtl/nta_ctrl.sv
// Controller: takes items, one datapath step per cycle unless stalled, owns m_valid.
// Depends on nta_pkg; drives nta_datapath.
`default_nettype none

module nta_ctrl
    import nta_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output nta_cmd_t  cmd,
    input  wire nta_sts_t sts
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        cmd.load = (state_reg == ST_IDLE) && s_valid;
        // A step may overwrite the output register only once it is free.
        cmd.step = (state_reg == ST_RUN) && (!m_valid_reg || m_ready);

        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (cmd.step) begin
                    if (sts.emit) begin
                        m_valid_next = 1'b1;
                    end
                    if (sts.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

>>> rtl/number_to_ascii_formatter_core.sv
// Top level of the number-to-ASCII formatter.
// Depends on nta_pkg, nta_ctrl and nta_datapath.
`default_nettype none

// Converts a 32-bit unsigned value to ASCII characters, most significant first, one
// transfer per character with m_last_char on the final one. Decimal mode prints the
// minimal digit count; a value of 100000000 or more gives a single transfer with
// m_too_large set and no digit. Hex modes print the requested nibble count (0 or above
// 8 means 8). One item is worked at a time: the datapath takes one step per cycle, with
// no step while m_ready is held low and a character waits. Decimal mode scans every
// digit position and drops leading zeros, hex mode steps once per nibble, and an
// oversized decimal value takes a single step.
module number_to_ascii_formatter_core
    import nta_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [31:0] s_value,
    input  wire logic [3:0]  s_hex_width,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_digit_char,
    output logic             m_last_char,
    output logic             m_too_large
);

    nta_cmd_t cmd;
    nta_sts_t sts;

    nta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    nta_datapath u_datapath (
        .aclk         (aclk),
        .s_mode       (s_mode),
        .s_value      (s_value),
        .s_hex_width  (s_hex_width),
        .cmd          (cmd),
        .sts          (sts),
        .m_digit_char (m_digit_char),
        .m_last_char  (m_last_char),
        .m_too_large  (m_too_large)
    );

endmodule

`default_nettype wire
